// ===== sv/hostname_syntax_checker_assert.svh =====
// Assertion macros for the hostname syntax checker.
// Taken in by the checker file; needs no other file.
`ifndef HOSTNAME_SYNTAX_CHECKER_ASSERT_SVH
`define HOSTNAME_SYNTAX_CHECKER_ASSERT_SVH

// Checked on every rising edge outside of reset.
`define HSC_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("hostname checker: assertion failed");

// Checked on every rising edge, reset included.
`define HSC_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("hostname checker: assertion failed");

`endif

// ===== sv/hsc_pkg.sv =====
// Shared types, constants and the character classifier of the hostname checker.
// Used by hsc_front, hsc_back and the top level; depends on nothing.
package hsc_pkg;

  localparam int LENGTH_BITS = 10;
  localparam int NAME_W      = LENGTH_BITS;
  localparam int MAX_NAME_W  = 10;
  localparam int MAX_LABEL_W = 7;
  localparam int CFG_W       = MAX_NAME_W;
  localparam int CMP_W       = (NAME_W > MAX_NAME_W) ? NAME_W : MAX_NAME_W;

  localparam logic [MAX_NAME_W-1:0]  MAX_NAME_RESET  = MAX_NAME_W'(255);
  localparam logic [MAX_LABEL_W-1:0] MAX_LABEL_RESET = MAX_LABEL_W'(63);

  localparam logic [7:0] CHAR_DOT    = 8'h2E;
  localparam logic [7:0] CHAR_HYPHEN = 8'h2D;

  // Queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic {
    CFG_MAX_NAME  = 1'b0,
    CFG_MAX_LABEL = 1'b1
  } cfg_index_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_TOO_LONG    = 3'd1,
    ST_EMPTY_LABEL = 3'd2,
    ST_BAD_CHAR    = 3'd3,
    ST_NO_DOT      = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    CLS_LETTER,
    CLS_DIGIT,
    CLS_HYPHEN,
    CLS_DOT,
    CLS_OTHER
  } char_class_e;

  // One classified character as it travels from front to back.
  typedef struct packed {
    char_class_e cls;
    logic        last;
  } word_t;

  function automatic char_class_e classify(input logic [7:0] c);
    char_class_e cls;
    if (c inside {[8'd65:8'd90], [8'd97:8'd122]}) begin
      cls = CLS_LETTER;
    end else if (c inside {[8'd48:8'd57]}) begin
      cls = CLS_DIGIT;
    end else if (c == CHAR_HYPHEN) begin
      cls = CLS_HYPHEN;
    end else if (c == CHAR_DOT) begin
      cls = CLS_DOT;
    end else begin
      cls = CLS_OTHER;
    end
    return cls;
  endfunction

endpackage

// ===== sv/hostname_syntax_checker.sv =====
// Top level of the hostname syntax checker: configuration registers, front and back.
// Depends on hsc_pkg, hsc_front and hsc_back.
//
//   channel  direction  handshake              payload
//   in       to block   in_valid_i/in_stall_o  character_i, last_char_i
//   out      from block out_valid_o/out_stall_i status_o
//   cfg      to block   cfg_we_i               cfg_index_i, cfg_data_i
//
// One character is taken per cycle while in_stall_o is low; the final character's status is registered after the queue.
// The four-word queue sets how long the input keeps flowing while the output is stalled.
// Reset clears the scan state and sets the limits to 255 and 63; no clearing pass is needed.
module hostname_syntax_checker import hsc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       character_i,
  input  logic             last_char_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [2:0]       status_o,
  input  logic             cfg_we_i,
  input  logic             cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  logic [MAX_NAME_W-1:0]  max_name_q;
  logic [MAX_LABEL_W-1:0] max_label_q;
  logic                   q_valid;
  word_t                  q_word;
  logic                   q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_name_q  <= MAX_NAME_RESET;
      max_label_q <= MAX_LABEL_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_MAX_NAME:  max_name_q  <= cfg_data_i[MAX_NAME_W-1:0];
        CFG_MAX_LABEL: max_label_q <= cfg_data_i[MAX_LABEL_W-1:0];
        default: ;
      endcase
    end
  end

  hsc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .character_i (character_i),
    .last_char_i (last_char_i),
    .q_valid_o   (q_valid),
    .q_word_o    (q_word),
    .q_pop_i     (q_pop)
  );

  hsc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_word_i    (q_word),
    .q_pop_o     (q_pop),
    .max_name_i  (max_name_q),
    .max_label_i (max_label_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o)
  );

endmodule

// ===== sv/hsc_front.sv =====
// Front end: takes characters, classifies them and queues the words for the back end.
// Depends on hsc_pkg.
module hsc_front import hsc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] character_i,
  input  logic       last_char_i,
  output logic       q_valid_o,
  output word_t      q_word_o,
  input  logic       q_pop_i
);

  word_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  count_q, count_d;
  logic               push;
  logic               pop;
  word_t              in_word;

  assign in_stall_o = (count_q == QCNT_W'(QDEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (count_q != '0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_word_o   = mem_q[rd_ptr_q];

  always_comb begin
    in_word.cls  = classify(character_i);
    in_word.last = last_char_i;
  end

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_word;
    end
  end

endmodule

// ===== sv/hsc_back.sv =====
// Back end: scan state of the current name and the registered status output.
// Depends on hsc_pkg; fed by hsc_front.
module hsc_back import hsc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_valid_i,
  input  word_t                  q_word_i,
  output logic                   q_pop_o,
  input  logic [MAX_NAME_W-1:0]  max_name_i,
  input  logic [MAX_LABEL_W-1:0] max_label_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [2:0]             status_o
);

  logic [NAME_W-1:0]      name_count_q, name_count_d;
  logic                   name_too_long_q, name_too_long_d;
  logic [MAX_LABEL_W-1:0] label_count_q, label_count_d;
  logic                   dot_seen_q, dot_seen_d;
  logic                   prev_hyphen_q, prev_hyphen_d;
  status_e                first_err_q, first_err_d;
  logic                   out_valid_q, out_valid_d;
  status_e                status_q, status_d;
  status_e                step_err;
  status_e                final_status;
  logic                   first;

  // A final word may only leave the queue when the output register is free.
  assign q_pop_o = q_valid_i && (!q_word_i.last || !out_valid_q || !out_stall_i);

  always_comb begin
    first    = (label_count_q == '0);
    step_err = ST_OK;
    if (q_word_i.cls == CLS_DOT) begin
      if (first) begin
        step_err = ST_EMPTY_LABEL;
      end else if (prev_hyphen_q) begin
        step_err = ST_BAD_CHAR;
      end
    end else if (label_count_q >= max_label_i) begin
      step_err = ST_TOO_LONG;
    end else if (first && q_word_i.cls != CLS_LETTER) begin
      step_err = ST_BAD_CHAR;
    end else if (q_word_i.cls == CLS_OTHER) begin
      step_err = ST_BAD_CHAR;
    end

    name_too_long_d = name_too_long_q
                      || (CMP_W'(name_count_q) >= CMP_W'(max_name_i));
    name_count_d    = (name_count_q != '1) ? name_count_q + NAME_W'(1) : name_count_q;
    first_err_d     = (first_err_q == ST_OK) ? step_err : first_err_q;
    prev_hyphen_d   = (q_word_i.cls == CLS_HYPHEN);
    if (q_word_i.cls == CLS_DOT) begin
      dot_seen_d    = 1'b1;
      label_count_d = '0;
    end else begin
      dot_seen_d    = dot_seen_q;
      label_count_d = (label_count_q != '1) ? label_count_q + MAX_LABEL_W'(1)
                                            : label_count_q;
    end

    if (name_too_long_d) begin
      final_status = ST_TOO_LONG;
    end else if (first_err_d != ST_OK) begin
      final_status = first_err_d;
    end else if (!dot_seen_d) begin
      final_status = ST_NO_DOT;
    end else begin
      final_status = ST_OK;
    end

    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    if (q_pop_o && q_word_i.last) begin
      out_valid_d = 1'b1;
      status_d    = final_status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_count_q    <= '0;
      name_too_long_q <= 1'b0;
      label_count_q   <= '0;
      dot_seen_q      <= 1'b0;
      prev_hyphen_q   <= 1'b0;
      first_err_q     <= ST_OK;
      out_valid_q     <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (q_pop_o) begin
        if (q_word_i.last) begin
          name_count_q    <= '0;
          name_too_long_q <= 1'b0;
          label_count_q   <= '0;
          dot_seen_q      <= 1'b0;
          prev_hyphen_q   <= 1'b0;
          first_err_q     <= ST_OK;
        end else begin
          name_count_q    <= name_count_d;
          name_too_long_q <= name_too_long_d;
          label_count_q   <= label_count_d;
          dot_seen_q      <= dot_seen_d;
          prev_hyphen_q   <= prev_hyphen_d;
          first_err_q     <= first_err_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;

endmodule

// ===== sv/hsc_checker.sv =====
// Port-level assertions for the hostname syntax checker, bound to the top level.
// Depends on hostname_syntax_checker_assert.svh.
`include "hostname_syntax_checker_assert.svh"

module hsc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] status_o
);

  `HSC_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |-> (!out_valid_o && !in_stall_o))
  `HSC_ASSERT(a_status_range, clk_i, rst_ni, out_valid_o |-> (status_o <= 3'd4))
  `HSC_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> out_valid_o)
  `HSC_ASSERT(a_status_hold, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> $stable(status_o))

endmodule

bind hostname_syntax_checker hsc_checker u_hsc_checker (.*);

// ===== sim/tb.sv =====
// Self-checking testbench for the hostname syntax checker.
// Depends on hsc_pkg and hostname_syntax_checker; reads no files.
module tb;
  import hsc_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 6;
  localparam int PHASE_CHARS    = 80;
  localparam int N_SETTINGS     = 10;
  localparam int BIG_SETTING    = 3;
  localparam int STEADY_SETTING = 4;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [7:0]       character_i;
  logic             last_char_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [2:0]       status_o;
  logic             cfg_we_i;
  logic             cfg_index_i;
  logic [CFG_W-1:0] cfg_data_i;

  hostname_syntax_checker dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .character_i (character_i),
    .last_char_i (last_char_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Checker state mirrored in the testbench.
  logic [MAX_NAME_W-1:0]  name_limit;
  logic [MAX_LABEL_W-1:0] label_limit;
  logic [NAME_W-1:0]      name_len;
  logic                   name_over;
  logic [6:0]             label_len;
  logic                   dot_found;
  logic                   after_hyphen;
  status_e                scan_error;

  status_e    status_q[$];
  logic [7:0] name_buf[$];

  bit          gaps_on;
  int unsigned errors;
  int unsigned quiet_cycles;
  int unsigned names_sent;
  int unsigned chars_sent;
  int unsigned statuses_seen;

  typedef struct {
    logic [7:0] ch;
    logic       fin;
    bit         typed;
    status_e    st;
  } dir_row_t;

  // Short names covering each status code except ST_TOO_LONG, both character extremes and the
  // accepted trailing hyphen and trailing dot.
  dir_row_t dir_rows [23] = '{
    '{"a",   1'b1, 1'b1, ST_NO_DOT},
    '{"z",   1'b0, 1'b0, ST_OK},
    '{"9",   1'b0, 1'b0, ST_OK},
    '{".",   1'b0, 1'b0, ST_OK},
    '{"A",   1'b1, 1'b1, ST_OK},
    '{".",   1'b0, 1'b0, ST_OK},
    '{"Z",   1'b1, 1'b1, ST_EMPTY_LABEL},
    '{"a",   1'b0, 1'b0, ST_OK},
    '{"-",   1'b0, 1'b0, ST_OK},
    '{".",   1'b0, 1'b0, ST_OK},
    '{"b",   1'b1, 1'b1, ST_BAD_CHAR},
    '{"0",   1'b0, 1'b0, ST_OK},
    '{".",   1'b0, 1'b0, ST_OK},
    '{"a",   1'b1, 1'b1, ST_BAD_CHAR},
    '{"a",   1'b0, 1'b0, ST_OK},
    '{8'hFF, 1'b1, 1'b1, ST_BAD_CHAR},
    '{8'h00, 1'b1, 1'b1, ST_BAD_CHAR},
    '{"a",   1'b0, 1'b0, ST_OK},
    '{".",   1'b0, 1'b0, ST_OK},
    '{"b",   1'b0, 1'b0, ST_OK},
    '{"-",   1'b1, 1'b1, ST_OK},
    '{"y",   1'b0, 1'b0, ST_OK},
    '{".",   1'b1, 1'b1, ST_OK}
  };

  function automatic bit is_alpha(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit is_num(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  task automatic clear_scan();
    name_len     = '0;
    name_over    = 1'b0;
    label_len    = '0;
    dot_found    = 1'b0;
    after_hyphen = 1'b0;
    scan_error   = ST_OK;
  endtask

  task automatic flag_error(input status_e code);
    if (scan_error == ST_OK) scan_error = code;
  endtask

  // Limits are compared with the counts before they advance, so a
  // saturated counter still reports an over-long name or label.
  task automatic scan_char(input logic [7:0] c, input logic fin,
                           output bit has, output status_e st);
    bit lead;
    lead = (label_len == 0);
    if (CMP_W'(name_len) >= CMP_W'(name_limit)) name_over = 1'b1;
    if (name_len != '1) name_len = name_len + 1'b1;
    if (c == CHAR_DOT) begin
      if (lead) flag_error(ST_EMPTY_LABEL);
      else if (after_hyphen) flag_error(ST_BAD_CHAR);
      dot_found = 1'b1;
      label_len = '0;
    end else begin
      if (label_len >= label_limit) flag_error(ST_TOO_LONG);
      if (label_len != '1) label_len = label_len + 1'b1;
      if (lead && !is_alpha(c)) flag_error(ST_BAD_CHAR);
      if (!lead && !is_alpha(c) && !is_num(c) && c != CHAR_HYPHEN) flag_error(ST_BAD_CHAR);
    end
    after_hyphen = (c == CHAR_HYPHEN);
    has = fin;
    st  = ST_OK;
    if (fin) begin
      if (name_over) st = ST_TOO_LONG;
      else if (scan_error != ST_OK) st = scan_error;
      else if (!dot_found) st = ST_NO_DOT;
      clear_scan();
    end
  endtask

  // Each call starts at a fresh falling edge, so valid is assigned once per step.
  task automatic send_char(input logic [7:0] c, input logic fin,
                           input bit typed, input status_e typed_st);
    bit      has;
    status_e st;
    @(negedge clk_i);
    while (gaps_on && $urandom_range(0, 99) < 28) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    character_i <= c;
    last_char_i <= fin;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    chars_sent++;
    scan_char(c, fin, has, st);
    if (has) begin
      status_q.push_back(typed ? typed_st : st);
      names_sent++;
    end
  endtask

  // Stop the sender and wait until every expected status has come back.
  task automatic settle(input int pad);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (pad) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_index_e idx, input logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    if (idx == CFG_MAX_NAME) name_limit = data[MAX_NAME_W-1:0];
    else label_limit = data[MAX_LABEL_W-1:0];
  endtask

  function automatic logic [7:0] rand_letter();
    int unsigned k;
    k = $urandom_range(0, 51);
    return (k < 26) ? 8'("A" + k) : 8'("a" + k - 26);
  endfunction

  function automatic logic [7:0] rand_tail();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return rand_letter();
    if (r < 85) return 8'("0" + $urandom_range(0, 9));
    return CHAR_HYPHEN;
  endfunction

  // Builds a well-formed name of the given length; labels are either
  // exactly lab long or random up to lab, the last one cut short.
  task automatic make_name(input int total, input int lab, input bit fixed);
    int         run;
    int         want;
    logic [7:0] c;
    name_buf.delete();
    run  = 0;
    want = fixed ? lab : $urandom_range(1, lab);
    while (name_buf.size() < total) begin
      if (run == want) begin
        name_buf.push_back(CHAR_DOT);
        run  = 0;
        want = fixed ? lab : $urandom_range(1, lab);
      end else begin
        c = (run == 0) ? rand_letter() : rand_tail();
        if (c == CHAR_HYPHEN && (run == want - 1 || name_buf.size() == total - 1)) c = "x";
        name_buf.push_back(c);
        run++;
      end
    end
  endtask

  task automatic corrupt_name();
    int pos;
    pos = $urandom_range(0, name_buf.size() - 1);
    case ($urandom_range(0, 4))
      0: name_buf[pos] = 8'($urandom_range(0, 255));
      1: name_buf.insert(pos, CHAR_DOT);
      2: name_buf.push_back($urandom_range(0, 1) ? CHAR_DOT : CHAR_HYPHEN);
      3: name_buf.push_front(CHAR_DOT);
      default: begin
        name_buf.insert(pos, CHAR_DOT);
        name_buf.insert(pos, CHAR_HYPHEN);
      end
    endcase
  endtask

  task automatic random_name();
    int total;
    int lab;
    bit fixed;
    int n;
    if ($urandom_range(0, 99) < 22) begin
      name_buf.delete();
      n = $urandom_range(1, 10);
      repeat (n) begin
        case ($urandom_range(0, 5))
          0, 1, 2: name_buf.push_back(8'($urandom_range(0, 255)));
          3: name_buf.push_back(CHAR_DOT);
          4: name_buf.push_back(CHAR_HYPHEN);
          default: name_buf.push_back(rand_tail());
        endcase
      end
    end else begin
      total = $urandom_range(1, 14);
      if ($urandom_range(0, 99) < 10 && name_limit <= 100)
        total = int'(name_limit) + $urandom_range(0, 2) - 1;
      if (total < 1) total = 1;
      fixed = ($urandom_range(0, 99) < 10);
      if (fixed) begin
        lab = int'(label_limit) + $urandom_range(0, 2) - 1;
        if (lab < 1) lab = 1;
        if (total < lab + 1) total = lab + 1 + $urandom_range(0, 2);
      end else begin
        lab = $urandom_range(1, 6);
      end
      make_name(total, lab, fixed);
      if ($urandom_range(0, 99) < 30) corrupt_name();
    end
  endtask

  task automatic send_name(input bit may_pause);
    for (int i = 0; i < name_buf.size(); i++) begin
      if (may_pause && i > 0 && $urandom_range(0, 99) < 3) settle(0);
      send_char(name_buf[i], i == name_buf.size() - 1, 1'b0, ST_OK);
    end
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= gaps_on && ($urandom_range(0, 99) < 28);
  end

  // Status checker and watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (out_valid_o && !out_stall_i) begin
        statuses_seen++;
        if (status_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("ERROR: status %0d with none expected", status_o);
        end else begin
          if (status_o !== status_q[0]) begin
            errors++;
            if (errors <= 10)
              $display("ERROR: status expected %0d got %0d", status_q[0], status_o);
          end
          void'(status_q.pop_front());
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("ERROR: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("** hostname_syntax_checker: FAILED **");
        $finish;
      end
    end
  end

  int set_name  [N_SETTINGS];
  int set_label [N_SETTINGS];
  int start_chars;

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    character_i = '0;
    last_char_i = 1'b0;
    out_stall_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = CFG_MAX_NAME;
    cfg_data_i  = '0;
    gaps_on     = 1'b1;
    errors      = 0;
    quiet_cycles  = 0;
    names_sent    = 0;
    chars_sent    = 0;
    statuses_seen = 0;
    name_limit  = MAX_NAME_RESET;
    label_limit = MAX_LABEL_RESET;
    clear_scan();

    set_name  = '{255, 1, 0, 1023, 12, 20, 0, 0, 0, 255};
    set_label = '{63,  1, 0, 127,  4,  3,  0, 0, 0, 63};
    for (int s = 6; s < 9; s++) begin
      set_name[s]  = $urandom_range(1, 40);
      set_label[s] = $urandom_range(1, 10);
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed names at the reset limits.
    foreach (dir_rows[i])
      send_char(dir_rows[i].ch, dir_rows[i].fin, dir_rows[i].typed, dir_rows[i].st);

    for (int s = 0; s < N_SETTINGS; s++) begin
      settle(SETTLE_CYCLES);
      write_reg(CFG_MAX_NAME, CFG_W'(set_name[s]));
      write_reg(CFG_MAX_LABEL, {3'($urandom_range(0, 7)), 7'(set_label[s])});
      @(negedge clk_i);
      cfg_we_i <= 1'b0;
      gaps_on = (s != STEADY_SETTING);
      if (s == BIG_SETTING) begin
        // A label right at the full-width label limit, then one of 130 characters, past it and
        // past the label counter's saturation point.
        make_name(128, 127, 1'b1);
        send_name(1'b0);
        make_name(130, 130, 1'b1);
        send_name(1'b0);
      end
      start_chars = chars_sent;
      while (chars_sent - start_chars < PHASE_CHARS) begin
        random_name();
        send_name(1'b1);
      end
    end

    settle(SETTLE_CYCLES);
    if (status_q.size() != 0) begin
      errors++;
      $display("ERROR: %0d statuses never arrived", status_q.size());
    end
    $display("Sent %0d names (%0d characters) under %0d limit settings;", names_sent,
             chars_sent, N_SETTINGS + 1);
    $display("checked %0d statuses, %0d mismatches.", statuses_seen, errors);
    if (errors == 0) begin
      $display("** hostname_syntax_checker: PASSED **");
    end else begin
      $display("** hostname_syntax_checker: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/hsc_pkg.sv
sv/hsc_front.sv
sv/hsc_back.sv
sv/hostname_syntax_checker.sv
sv/hsc_checker.sv
sim/tb.sv
